/* sv/pqe_pkg.sv */
// ----------------------------------------------------------------------------
// pqe_pkg
// Shared types and constants of the polygon query engine.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int MaxVertices = 64;
  localparam int CoordBits   = 16;
  localparam int CountBits   = $clog2(MaxVertices + 1);
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int AreaBits    = 39;
  localparam int MinPoly     = 3;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_POINT  = 3'd2;
  localparam logic [2:0] CMD_AREA   = 3'd3;
  localparam logic [2:0] CMD_CONVEX = 3'd4;

  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_AREA   = 2'd1;
  localparam logic [1:0] KIND_CONVEX = 2'd2;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic  valid;
    vertex_t v;
  } edge_tok_t;

endpackage

/* sv/pqe_ram.sv */
// ----------------------------------------------------------------------------
// pqe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pqe_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/pqe_cell.sv */
// ----------------------------------------------------------------------------
// pqe_cell
// One cell of the vertex chain: holds one vertex and passes the older one on.
// ----------------------------------------------------------------------------
module pqe_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                flush,
  input  pqe_pkg::edge_tok_t  tok_in,
  output pqe_pkg::edge_tok_t  tok_out
);

  pqe_pkg::edge_tok_t tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_in.valid;
    end
    tok_r.v <= tok_in.v;
  end

  assign tok_out = tok_r;

endmodule

/* sv/pqe_eval.sv */
// ----------------------------------------------------------------------------
// pqe_eval
// Edge evaluator: crossing test, shoelace term and turn sign, with registered products.
// ----------------------------------------------------------------------------
module pqe_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                flush,
  input  logic                en,
  input  pqe_pkg::coord_t     px,
  input  pqe_pkg::coord_t     py,
  input  pqe_pkg::vertex_t    va,
  input  pqe_pkg::vertex_t    vb,
  input  pqe_pkg::vertex_t    vc,
  output logic                out_en,
  output logic                hit,
  output logic signed [2*pqe_pkg::CoordBits+1:0] shoe,
  output logic [1:0]          turn
);

  localparam int PW = 2 * pqe_pkg::CoordBits + 4;

  logic signed [pqe_pkg::CoordBits:0] dy, pxa, dxab, pya;
  logic signed [pqe_pkg::CoordBits:0] bax, bay, cbx, cby;
  logic span;

  logic                  en_r, span_r, pos_r;
  logic signed [PW-1:0]  lhs_r, rhs_r, sa_r, sb_r, ca_r, cb_r;

  always_comb begin
    dy   = {vb.y[pqe_pkg::CoordBits-1], vb.y} - {va.y[pqe_pkg::CoordBits-1], va.y};
    pxa  = {px[pqe_pkg::CoordBits-1], px} - {va.x[pqe_pkg::CoordBits-1], va.x};
    dxab = {vb.x[pqe_pkg::CoordBits-1], vb.x} - {va.x[pqe_pkg::CoordBits-1], va.x};
    pya  = {py[pqe_pkg::CoordBits-1], py} - {va.y[pqe_pkg::CoordBits-1], va.y};
    bax  = dxab;
    bay  = dy;
    cbx  = {vc.x[pqe_pkg::CoordBits-1], vc.x} - {vb.x[pqe_pkg::CoordBits-1], vb.x};
    cby  = {vc.y[pqe_pkg::CoordBits-1], vc.y} - {vb.y[pqe_pkg::CoordBits-1], vb.y};
    span = (va.y > py) != (vb.y > py);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      en_r <= 1'b0;
    end else begin
      en_r <= en;
    end
    span_r <= span;
    pos_r  <= dy > 0;
    lhs_r  <= PW'(pxa * dy);
    rhs_r  <= PW'(dxab * pya);
    sa_r   <= PW'(va.x * vb.y);
    sb_r   <= PW'(vb.x * va.y);
    ca_r   <= PW'(bax * cby);
    cb_r   <= PW'(bay * cbx);
  end

  always_comb begin
    logic signed [PW-1:0] cr;
    cr     = ca_r - cb_r;
    out_en = en_r;
    hit    = span_r && (pos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r));
    shoe   = (2*pqe_pkg::CoordBits+2)'(sa_r - sb_r);
    turn   = {cr < 0, cr > 0};
  end

endmodule

/* sv/polygon_query_engine.sv */
// ----------------------------------------------------------------------------
// polygon_query_engine
// Polygon store with point-in-polygon, twice-area and convexity queries.
// Append, clear and ignored commands are taken one per cycle while idle. A
// query streams the vertex memory, one vertex per cycle, through three cells
// and an edge evaluator; its result word is registered after the last edge
// leaves it. Queries below three vertices and point queries outside the box
// skip the stream. A waiting result stalls input once the next query is done.
// Synchronous active-low reset empties the store; memory contents stay.
// ----------------------------------------------------------------------------
module polygon_query_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic signed [pqe_pkg::CoordBits-1:0] in_x_coord,
  input  logic signed [pqe_pkg::CoordBits-1:0] in_y_coord,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_query_kind,
  output logic        out_inside_res,
  output logic        out_convex,
  output logic [pqe_pkg::AreaBits-1:0] out_area_twice
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  localparam int CB = pqe_pkg::CountBits;
  localparam int IB = pqe_pkg::IdxBits;
  localparam int SW = 2 * pqe_pkg::CoordBits + 2;
  localparam int AW = pqe_pkg::AreaBits;

  state_t state_r;
  logic [CB-1:0] count_r, feed_r;
  logic [2:0] cmd_r;
  pqe_pkg::coord_t px_r, py_r, bminx_r, bmaxx_r, bminy_r, bmaxy_r;
  logic feed_on_r, rd_v_r;
  logic [CB-1:0] done_cnt_r;
  logic signed [pqe_pkg::AreaBits:0] sum_r;
  logic par_r, sgn_pos_r, sgn_neg_r;
  logic ov_r;
  logic [1:0] kind_r;
  logic ins_r, cvx_r;
  logic [AW-1:0] area_r;

  pqe_pkg::vertex_t rd_v;
  logic accept, flush;
  pqe_pkg::edge_tok_t tok_head, tok_c1, tok_c2, tok_c3;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign flush    = accept;

  pqe_ram #(.Width(2*pqe_pkg::CoordBits), .Depth(pqe_pkg::MaxVertices)) u_ram (
    .clk     (clk),
    .wr_en   (accept && in_cmd == pqe_pkg::CMD_APPEND && count_r < CB'(pqe_pkg::MaxVertices)),
    .wr_addr (count_r[IB-1:0]),
    .wr_data ({in_x_coord, in_y_coord}),
    .rd_addr (feed_r[IB-1:0]),
    .rd_data (rd_v)
  );

  // The stream is v0..v(n-1), then v0, v1 again so every edge and turn is seen.
  always_comb begin
    tok_head.valid = rd_v_r;
    tok_head.v     = rd_v;
  end

  pqe_cell u_c1 (.clk(clk), .rst_n(rst_n), .flush(flush), .tok_in(tok_head), .tok_out(tok_c1));
  pqe_cell u_c2 (.clk(clk), .rst_n(rst_n), .flush(flush), .tok_in(tok_c1), .tok_out(tok_c2));
  pqe_cell u_c3 (.clk(clk), .rst_n(rst_n), .flush(flush), .tok_in(tok_c2), .tok_out(tok_c3));

  logic ev_en, ev_oen, ev_hit;
  logic signed [SW-1:0] ev_shoe;
  logic [1:0] ev_turn;

  // Cell 3 holds vertex a, cell 2 vertex b, cell 1 vertex c.
  assign ev_en = tok_c3.valid && tok_c2.valid && tok_c1.valid;

  pqe_eval u_eval (
    .clk(clk), .rst_n(rst_n), .flush(flush), .en(ev_en),
    .px(px_r), .py(py_r), .va(tok_c3.v), .vb(tok_c2.v), .vc(tok_c1.v),
    .out_en(ev_oen), .hit(ev_hit), .shoe(ev_shoe), .turn(ev_turn)
  );

  logic inbox;
  assign inbox = !(in_x_coord < bminx_r || in_x_coord > bmaxx_r ||
                   in_y_coord < bminy_r || in_y_coord > bmaxy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      feed_on_r <= 1'b0;
      rd_v_r    <= 1'b0;
      ov_r      <= 1'b0;
      bminx_r   <= '0;
      bmaxx_r   <= '0;
      bminy_r   <= '0;
      bmaxy_r   <= '0;
    end else begin
      if (state_r == ST_DONE && (!ov_r || out_ready)) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      rd_v_r <= feed_on_r;
      if (feed_on_r) begin
        done_cnt_r <= done_cnt_r + CB'(1);
        if (done_cnt_r == count_r + CB'(1)) begin
          feed_on_r <= 1'b0;
        end
        feed_r <= (feed_r == count_r - CB'(1)) ? '0 : feed_r + CB'(1);
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r <= in_cmd;
            px_r  <= in_x_coord;
            py_r  <= in_y_coord;
            case (in_cmd)
              pqe_pkg::CMD_CLEAR: begin
                count_r <= '0;
                bminx_r <= '0;
                bmaxx_r <= '0;
                bminy_r <= '0;
                bmaxy_r <= '0;
              end
              pqe_pkg::CMD_APPEND: begin
                if (count_r < CB'(pqe_pkg::MaxVertices)) begin
                  count_r <= count_r + CB'(1);
                  if (count_r == '0) begin
                    bminx_r <= in_x_coord;
                    bmaxx_r <= in_x_coord;
                    bminy_r <= in_y_coord;
                    bmaxy_r <= in_y_coord;
                  end else begin
                    if (in_x_coord < bminx_r) bminx_r <= in_x_coord;
                    if (in_x_coord > bmaxx_r) bmaxx_r <= in_x_coord;
                    if (in_y_coord < bminy_r) bminy_r <= in_y_coord;
                    if (in_y_coord > bmaxy_r) bmaxy_r <= in_y_coord;
                  end
                end
              end
              pqe_pkg::CMD_POINT, pqe_pkg::CMD_AREA, pqe_pkg::CMD_CONVEX: begin
                sum_r     <= '0;
                par_r     <= 1'b0;
                sgn_pos_r <= 1'b0;
                sgn_neg_r <= 1'b0;
                if (count_r < CB'(pqe_pkg::MinPoly) ||
                    (in_cmd == pqe_pkg::CMD_POINT && !inbox)) begin
                  state_r <= ST_DONE;
                end else begin
                  state_r    <= ST_RUN;
                  feed_on_r  <= 1'b1;
                  feed_r     <= '0;
                  done_cnt_r <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (ev_oen) begin
            sum_r     <= sum_r + (pqe_pkg::AreaBits+1)'(ev_shoe);
            par_r     <= par_r ^ ev_hit;
            sgn_pos_r <= sgn_pos_r | ev_turn[0];
            sgn_neg_r <= sgn_neg_r | ev_turn[1];
          end
          if (!feed_on_r && !rd_v_r && !tok_c1.valid && !tok_c2.valid &&
              !tok_c3.valid && !ev_oen) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!ov_r || out_ready) begin
            state_r <= ST_IDLE;
            case (cmd_r)
              pqe_pkg::CMD_POINT: begin
                kind_r <= pqe_pkg::KIND_POINT;
                ins_r  <= (count_r >= CB'(pqe_pkg::MinPoly)) && par_r;
                cvx_r  <= 1'b0;
                area_r <= '0;
              end
              pqe_pkg::CMD_AREA: begin
                kind_r <= pqe_pkg::KIND_AREA;
                ins_r  <= 1'b0;
                cvx_r  <= 1'b0;
                area_r <= sum_r[pqe_pkg::AreaBits] ? AW'(-sum_r) : AW'(sum_r);
              end
              default: begin
                kind_r <= pqe_pkg::KIND_CONVEX;
                ins_r  <= 1'b0;
                cvx_r  <= (count_r >= CB'(pqe_pkg::MinPoly)) && !(sgn_pos_r && sgn_neg_r);
                area_r <= '0;
              end
            endcase
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = ov_r;
  assign out_query_kind = kind_r;
  assign out_inside_res = ins_r;
  assign out_convex     = cvx_r;
  assign out_area_twice = area_r;

endmodule

/* sv/pqe_checker.sv */
// ----------------------------------------------------------------------------
// pqe_checker
// Port-level checks of the polygon query engine.
// ----------------------------------------------------------------------------
module pqe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_query_kind,
  input logic        out_inside_res,
  input logic        out_convex,
  input logic [38:0] out_area_twice
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_area_twice))
    else $error("result word dropped while stalled");

  a_hold_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_query_kind, out_inside_res, out_convex}))
    else $error("result word changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_query_kind == pqe_pkg::KIND_POINT ||
                   out_query_kind == pqe_pkg::KIND_AREA ||
                   out_query_kind == pqe_pkg::KIND_CONVEX))
    else $error("bad query kind");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_query_kind != pqe_pkg::KIND_AREA |-> out_area_twice == '0)
    else $error("area set on a non-area result");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inside_res && out_convex))
    else $error("two result flags set");

endmodule

bind polygon_query_engine pqe_checker u_pqe_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_ready(out_ready), .out_query_kind(out_query_kind),
  .out_inside_res(out_inside_res), .out_convex(out_convex),
  .out_area_twice(out_area_twice)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polygon query engine. Command words are queued
// by a stimulus process, sent by a bursty driver and predicted on acceptance
// by a polygon model inside the bench; results are compared in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] x;
    logic [15:0] y;
  } word_t;

  typedef struct {
    logic [1:0]  kind;
    logic        in_poly;
    logic        convex;
    logic [38:0] area;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd = '0;
  logic signed [15:0] in_x_coord = '0;
  logic signed [15:0] in_y_coord = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_query_kind;
  logic        out_inside_res;
  logic        out_convex;
  logic [38:0] out_area_twice;

  polygon_query_engine dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  word_t   pending_words[$];
  answer_t expected_answers[$];
  int      error_count = 0;
  bit      stimulus_done = 1'b0;
  bit      hold_sender = 1'b0;
  bit      long_stall = 1'b0;

  longint  poly_x[pqe_pkg::MaxVertices];
  longint  poly_y[pqe_pkg::MaxVertices];
  int      poly_count = 0;
  longint  bmin_x, bmax_x, bmin_y, bmax_y;

  task automatic report(input string what, input longint got, input longint want);
    $display("Mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic bit point_inside(input longint px, input longint py);
    int     crossings;
    int     j;
    longint dy, lhs, rhs;
    crossings = 0;
    if (poly_count < pqe_pkg::MinPoly) return 1'b0;
    if (px < bmin_x || px > bmax_x || py < bmin_y || py > bmax_y) return 1'b0;
    for (int i = 0; i < poly_count; i++) begin
      j = (i + 1) % poly_count;
      if ((poly_y[i] > py) != (poly_y[j] > py)) begin
        dy  = poly_y[j] - poly_y[i];
        lhs = (px - poly_x[i]) * dy;
        rhs = (poly_x[j] - poly_x[i]) * (py - poly_y[i]);
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) crossings++;
      end
    end
    return crossings[0];
  endfunction

  function automatic logic [38:0] twice_area();
    longint sum;
    int     j;
    sum = 0;
    if (poly_count < pqe_pkg::MinPoly) return '0;
    for (int i = 0; i < poly_count; i++) begin
      j = (i + 1) % poly_count;
      sum += poly_x[i] * poly_y[j] - poly_x[j] * poly_y[i];
    end
    if (sum < 0) sum = -sum;
    return sum[38:0];
  endfunction

  function automatic bit polygon_convex();
    int     sgn, dir, j, k;
    longint cr;
    sgn = 0;
    if (poly_count < pqe_pkg::MinPoly) return 1'b0;
    for (int i = 0; i < poly_count; i++) begin
      j = (i + 1) % poly_count;
      k = (i + 2) % poly_count;
      cr = (poly_x[j] - poly_x[i]) * (poly_y[k] - poly_y[j])
         - (poly_y[j] - poly_y[i]) * (poly_x[k] - poly_x[j]);
      dir = (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
      if (dir != 0) begin
        if (sgn == 0) sgn = dir;
        else if (sgn != dir) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic apply_word(input word_t w);
    longint  px, py;
    answer_t a;
    px = longint'($signed(w.x));
    py = longint'($signed(w.y));
    a = '{kind: pqe_pkg::KIND_POINT, in_poly: 1'b0, convex: 1'b0, area: '0};
    case (w.cmd)
      pqe_pkg::CMD_CLEAR: begin
        poly_count = 0;
        bmin_x = 0; bmax_x = 0; bmin_y = 0; bmax_y = 0;
      end
      pqe_pkg::CMD_APPEND: begin
        if (poly_count < pqe_pkg::MaxVertices) begin
          if (poly_count == 0) begin
            bmin_x = px; bmax_x = px; bmin_y = py; bmax_y = py;
          end else begin
            if (px < bmin_x) bmin_x = px;
            if (px > bmax_x) bmax_x = px;
            if (py < bmin_y) bmin_y = py;
            if (py > bmax_y) bmax_y = py;
          end
          poly_x[poly_count] = px;
          poly_y[poly_count] = py;
          poly_count++;
        end
      end
      pqe_pkg::CMD_POINT: begin
        a.in_poly = point_inside(px, py);
        expected_answers.push_back(a);
      end
      pqe_pkg::CMD_AREA: begin
        a.kind = pqe_pkg::KIND_AREA;
        a.area = twice_area();
        expected_answers.push_back(a);
      end
      pqe_pkg::CMD_CONVEX: begin
        a.kind = pqe_pkg::KIND_CONVEX;
        a.convex = polygon_convex();
        expected_answers.push_back(a);
      end
      default: ;
    endcase
  endtask

  // Driver: bursts of words separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_word('{cmd: in_cmd, x: in_x_coord, y: in_y_coord});
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !hold_sender) begin
          word_t w;
          w = pending_words.pop_front();
          in_cmd <= w.cmd;
          in_x_coord <= w.x;
          in_y_coord <= w.y;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: periodic stall pattern mixed with random stalls, plus one long hold-off.
  int stall_phase = 0;
  int long_left = 0;
  bit long_taken = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 97;
      if (long_left > 0) begin
        long_left <= long_left - 1;
        out_ready <= 1'b0;
      end else if (long_stall && !long_taken) begin
        long_taken <= 1'b1;
        long_left <= 800;
        out_ready <= 1'b0;
      end else if (stall_phase < 40) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $display("Unexpected result word at %0t", $realtime);
        error_count++;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (out_query_kind !== e.kind) report("query_kind", out_query_kind, e.kind);
        if (out_inside_res !== e.in_poly) report("inside_res", out_inside_res, e.in_poly);
        if (out_convex !== e.convex) report("convex", out_convex, e.convex);
        if (out_area_twice !== e.area) report("area_twice", out_area_twice, e.area);
      end
    end
  end

  // Watchdog.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic word_t mk(input logic [2:0] c, input logic [15:0] x,
                               input logic [15:0] y);
    return '{cmd: c, x: x, y: y};
  endfunction

  task automatic queue_polygon(input int n, input int radius);
    int cx, cy;
    pending_words.push_back(mk(pqe_pkg::CMD_CLEAR, '0, '0));
    cx = $urandom_range(0, 2 * (32767 - radius)) - (32767 - radius);
    cy = $urandom_range(0, 2 * (32767 - radius)) - (32767 - radius);
    for (int i = 0; i < n; i++) begin
      real a;
      int  r;
      a = 6.283185307 * i / n;
      r = ($urandom_range(0, 2) == 0) ? $urandom_range(1, radius) : radius;
      pending_words.push_back(mk(pqe_pkg::CMD_APPEND, 16'(cx + int'(r * $cos(a))),
                                 16'(cy + int'(r * $sin(a)))));
    end
    for (int q = $urandom_range(2, 8); q > 0; q--) begin
      case ($urandom_range(0, 3))
        0: pending_words.push_back(mk(pqe_pkg::CMD_AREA, rand_coord(), rand_coord()));
        1: pending_words.push_back(mk(pqe_pkg::CMD_CONVEX, rand_coord(), rand_coord()));
        default: pending_words.push_back(mk(pqe_pkg::CMD_POINT,
                   16'(cx + $urandom_range(0, 2 * radius + 4) - radius - 2),
                   16'(cy + $urandom_range(0, 2 * radius + 4) - radius - 2)));
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-store queries, bad commands, degenerate and extreme polygons.
    pending_words.push_back(mk(pqe_pkg::CMD_POINT, '0, '0));
    pending_words.push_back(mk(pqe_pkg::CMD_AREA, '0, '0));
    pending_words.push_back(mk(pqe_pkg::CMD_CONVEX, '0, '0));
    pending_words.push_back(mk(3'd5, 16'hffff, 16'hffff));
    pending_words.push_back(mk(3'd7, '0, '0));
    pending_words.push_back(mk(pqe_pkg::CMD_APPEND, 16'h8000, 16'h8000));
    pending_words.push_back(mk(pqe_pkg::CMD_APPEND, 16'h7fff, 16'h8000));
    pending_words.push_back(mk(pqe_pkg::CMD_AREA, '0, '0));
    pending_words.push_back(mk(pqe_pkg::CMD_APPEND, 16'h7fff, 16'h7fff));
    pending_words.push_back(mk(pqe_pkg::CMD_APPEND, 16'h8000, 16'h7fff));
    pending_words.push_back(mk(pqe_pkg::CMD_POINT, '0, '0));
    pending_words.push_back(mk(pqe_pkg::CMD_POINT, 16'h8000, 16'h8000));
    pending_words.push_back(mk(pqe_pkg::CMD_POINT, 16'h7fff, 16'h7fff));
    pending_words.push_back(mk(pqe_pkg::CMD_AREA, '0, '0));
    pending_words.push_back(mk(pqe_pkg::CMD_CONVEX, '0, '0));
    pending_words.push_back(mk(pqe_pkg::CMD_CLEAR, '0, '0));
    pending_words.push_back(mk(pqe_pkg::CMD_APPEND, 16'd1, 16'd1));
    pending_words.push_back(mk(pqe_pkg::CMD_APPEND, 16'd2, 16'd2));
    pending_words.push_back(mk(pqe_pkg::CMD_APPEND, 16'd3, 16'd3));
    pending_words.push_back(mk(pqe_pkg::CMD_CONVEX, '0, '0));
    pending_words.push_back(mk(pqe_pkg::CMD_POINT, 16'd2, 16'd2));
    pending_words.push_back(mk(pqe_pkg::CMD_AREA, '0, '0));
    wait_drained();

    // Fill past capacity, with a long receiver stall to back up the block.
    pending_words.push_back(mk(pqe_pkg::CMD_CLEAR, '0, '0));
    for (int i = 0; i < pqe_pkg::MaxVertices + 4; i++)
      pending_words.push_back(mk(pqe_pkg::CMD_APPEND, rand_coord(), rand_coord()));
    long_stall = 1'b1;
    for (int i = 0; i < 8; i++)
      pending_words.push_back(mk(pqe_pkg::CMD_AREA + 3'(i % 2), rand_coord(), rand_coord()));
    wait_drained();

    // Random: mostly well-formed polygons, some noise.
    for (int k = 0; k < 100; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          pending_words.push_back(mk(3'($urandom_range(0, 7)), 16'($urandom),
                                     16'($urandom)));
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, pqe_pkg::MaxVertices + 2)
                                       : $urandom_range(3, 10);
        queue_polygon(n, ($urandom_range(0, 3) == 0) ? 32000 : $urandom_range(2, 3000));
      end
      if (k == 55) begin
        hold_sender = 1'b1;
        while (in_valid || expected_answers.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      while (pending_words.size() > 40) @(posedge clk);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
sv/pqe_pkg.sv
sv/pqe_ram.sv
sv/pqe_cell.sv
sv/pqe_eval.sv
sv/polygon_query_engine.sv
sv/pqe_checker.sv
tb/tb_top.sv
